@@ rtl/yti_pkg.sv @@
// Shared types and constants for the YUY2 to I420 converter.
// No dependencies; imported by the line store and the top level.
`default_nettype none

package yti_pkg;

    // Configuration register layout.
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] RESET_FRAME_WIDTH  = 13'd640;
    localparam logic [CFG_W-1:0] RESET_FRAME_HEIGHT = 13'd480;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int OFFSET_W = 24;

    typedef enum logic [1:0] {
        PLANE_LUMA = 2'd0,
        PLANE_BLUE = 2'd1,
        PLANE_RED  = 2'd2
    } plane_t;

    // One entry of the chroma line store.
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] red;
    } chroma_word_t;

endpackage

`default_nettype wire

@@ rtl/yti_line_store.sv @@
// Chroma line store: one write port, one read port, registered read data.
// Uses chroma_word_t from yti_pkg.
`default_nettype none

module yti_line_store
    import yti_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_WIDTH / 2,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire chroma_word_t  wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output chroma_word_t       rd_data
);

    chroma_word_t mem [DEPTH];
    chroma_word_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ rtl/yuy2_to_i420_converter.sv @@
// Top level of the YUY2 to I420 converter: counters, line store access and
// result sequencing. Depends on yti_pkg and yti_line_store.
`default_nettype none

// Each accepted word is one Y0 U Y1 V pixel pair in raster order. A pair
// yields only its luma write (even rows that are not the last row), or
// also U and V writes (odd rows, and the last row of an odd-height frame):
// the single result port moves one write per cycle unless m_ready stalls
// it. The first result word of a pair passes through the work stage and
// then the output register before it is presented. Chroma of even rows is
// kept in an on-chip line store of MAX_WIDTH/2 entries, read at the
// accepting edge so that its data is ready in the work stage; it needs no
// clearing after reset. With an odd frame_width every pair yields one
// result with width_error set and the position counters stand still. Write
// frame_width and frame_height only while the block is idle.
module yuy2_to_i420_converter
    import yti_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,

    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [7:0]           s_luma_first,
    input  wire logic [7:0]           s_chroma_blue,
    input  wire logic [7:0]           s_luma_second,
    input  wire logic [7:0]           s_chroma_red,

    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [1:0]                m_plane,
    output logic [OFFSET_W-1:0]       m_offset,
    output logic [7:0]                m_byte_first,
    output logic [7:0]                m_byte_second,
    output logic                      m_pair,
    output logic                      m_last_of_run,
    output logic                      m_frame_end,
    output logic                      m_width_error
);

    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int PW = $clog2(LINE_DEPTH + 1);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int MAX_W_EVEN = MAX_WIDTH - (MAX_WIDTH % 2);
    localparam int LW = RW + WW + 1;
    localparam int CW = RW + PW + 1;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= RESET_FRAME_WIDTH;
            frame_height_reg <= RESET_FRAME_HEIGHT;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic          width_odd;
    logic [WW-1:0] width_sat;
    logic [HW-1:0] height_sat;
    logic [PW-1:0] pairs;

    assign width_odd = frame_width_reg[0];

    always_comb begin
        if (frame_width_reg == '0) begin
            width_sat = WW'(2);
        end else if (32'(frame_width_reg) > 32'(MAX_W_EVEN)) begin
            width_sat = WW'(MAX_W_EVEN);
        end else begin
            width_sat = WW'(frame_width_reg);
        end

        if (frame_height_reg == '0) begin
            height_sat = HW'(1);
        end else if (32'(frame_height_reg) > 32'(MAX_HEIGHT)) begin
            height_sat = HW'(MAX_HEIGHT);
        end else begin
            height_sat = HW'(frame_height_reg);
        end
    end

    assign pairs = PW'(width_sat >> 1);

    // ------------------------------------------------------------------
    // Position counters, updated when a word is accepted with even width
    // ------------------------------------------------------------------
    logic [AW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic          in_fire;
    logic          row_end;
    logic          last_row;
    logic          frame_last;
    logic          odd_row;

    assign in_fire    = s_valid && s_ready;
    assign row_end    = (32'(col_reg) + 32'd1) >= 32'(pairs);
    assign last_row   = (32'(row_reg) + 32'd1) >= 32'(height_sat);
    assign frame_last = row_end && last_row;
    assign odd_row    = row_reg[0];

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_fire && !width_odd) begin
            if (frame_last) begin
                col_next = '0;
                row_next = '0;
            end else if (row_end) begin
                col_next = '0;
                row_next = row_reg + RW'(1);
            end else begin
                col_next = col_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Line store: even rows write, odd rows read at the same column.
    // Both happen at the accepting edge, so a read always sees every
    // earlier write.
    // ------------------------------------------------------------------
    chroma_word_t store_wr_data;
    chroma_word_t store_rd_data;
    logic         store_wr_en;
    logic         store_rd_en;

    assign store_wr_data.blue = s_chroma_blue;
    assign store_wr_data.red  = s_chroma_red;
    assign store_wr_en = in_fire && !width_odd && !odd_row;
    assign store_rd_en = in_fire && !width_odd && odd_row;

    yti_line_store #(
        .DEPTH (LINE_DEPTH),
        .AW    (AW)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (store_wr_en),
        .wr_addr (col_reg),
        .wr_data (store_wr_data),
        .rd_en   (store_rd_en),
        .rd_addr (col_reg),
        .rd_data (store_rd_data)
    );

    // ------------------------------------------------------------------
    // Work stage: holds one pair while its results are sent out
    // ------------------------------------------------------------------
    logic          s1_valid_reg, s1_valid_next;
    logic [1:0]    idx_reg, idx_next;
    logic          s1_err_reg;
    logic          s1_odd_reg;
    logic          s1_three_reg;
    logic          s1_flast_reg;
    logic [RW-1:0] s1_row_reg;
    logic [AW-1:0] s1_col_reg;
    logic [WW-1:0] s1_w_reg;
    logic [PW-1:0] s1_pairs_reg;
    logic [7:0]    s1_y0_reg;
    logic [7:0]    s1_y1_reg;
    logic [7:0]    s1_u_reg;
    logic [7:0]    s1_v_reg;

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            s1_err_reg   <= width_odd;
            s1_odd_reg   <= odd_row;
            s1_three_reg <= odd_row || last_row;
            s1_flast_reg <= frame_last;
            s1_row_reg   <= row_reg;
            s1_col_reg   <= col_reg;
            s1_w_reg     <= width_sat;
            s1_pairs_reg <= pairs;
            s1_y0_reg    <= s_luma_first;
            s1_y1_reg    <= s_luma_second;
            s1_u_reg     <= s_chroma_blue;
            s1_v_reg     <= s_chroma_red;
        end
    end

    logic [LW-1:0]       luma_sum;
    logic [CW-1:0]       chroma_sum;
    logic [7:0]          blue_byte;
    logic [7:0]          red_byte;
    logic [1:0]          last_idx;
    logic                last_now;
    logic                advance;
    plane_t              res_plane;
    logic [OFFSET_W-1:0] res_offset;
    logic [7:0]          res_first;
    logic [7:0]          res_second;
    logic                res_pair;

    assign luma_sum   = LW'(s1_row_reg * s1_w_reg) + LW'({s1_col_reg, 1'b0});
    assign chroma_sum = CW'((s1_row_reg >> 1) * s1_pairs_reg) + CW'(s1_col_reg);

    // Odd rows average with the stored even-row chroma, truncating.
    assign blue_byte = s1_odd_reg
        ? 8'((9'(store_rd_data.blue) + 9'(s1_u_reg)) >> 1) : s1_u_reg;
    assign red_byte  = s1_odd_reg
        ? 8'((9'(store_rd_data.red) + 9'(s1_v_reg)) >> 1) : s1_v_reg;

    assign last_idx = (s1_err_reg || !s1_three_reg) ? 2'd0 : 2'd2;
    assign last_now = (idx_reg == last_idx);
    assign advance  = s1_valid_reg && (!m_valid || m_ready);

    always_comb begin
        res_plane  = PLANE_LUMA;
        res_offset = '0;
        res_first  = '0;
        res_second = '0;
        res_pair   = 1'b0;
        if (!s1_err_reg) begin
            case (idx_reg)
                2'd0: begin
                    res_offset = OFFSET_W'(luma_sum);
                    res_first  = s1_y0_reg;
                    res_second = s1_y1_reg;
                    res_pair   = 1'b1;
                end
                2'd1: begin
                    res_plane  = PLANE_BLUE;
                    res_offset = OFFSET_W'(chroma_sum);
                    res_first  = blue_byte;
                end
                2'd2: begin
                    res_plane  = PLANE_RED;
                    res_offset = OFFSET_W'(chroma_sum);
                    res_first  = red_byte;
                end
                default: ;
            endcase
        end
    end

    assign s_ready = !s1_valid_reg || (advance && last_now);

    always_comb begin
        s1_valid_next = s1_valid_reg;
        idx_next      = idx_reg;
        if (advance) begin
            idx_next = last_now ? 2'd0 : idx_reg + 2'd1;
            if (last_now) begin
                s1_valid_next = 1'b0;
            end
        end
        if (in_fire) begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            idx_reg      <= '0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            idx_reg      <= idx_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic                m_valid_reg, m_valid_next;
    plane_t              m_plane_reg;
    logic [OFFSET_W-1:0] m_offset_reg;
    logic [7:0]          m_first_reg;
    logic [7:0]          m_second_reg;
    logic                m_pair_reg;
    logic                m_last_reg;
    logic                m_fend_reg;
    logic                m_err_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_plane_reg  <= res_plane;
            m_offset_reg <= res_offset;
            m_first_reg  <= res_first;
            m_second_reg <= res_second;
            m_pair_reg   <= res_pair;
            m_last_reg   <= last_now;
            m_fend_reg   <= last_now && s1_flast_reg && !s1_err_reg;
            m_err_reg    <= s1_err_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_plane       = m_plane_reg;
    assign m_offset      = m_offset_reg;
    assign m_byte_first  = m_first_reg;
    assign m_byte_second = m_second_reg;
    assign m_pair        = m_pair_reg;
    assign m_last_of_run = m_last_reg;
    assign m_frame_end   = m_fend_reg;
    assign m_width_error = m_err_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg |-> (idx_reg <= last_idx))
        else $error("result index ran past the last result of the pair");

    a_error_word_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_width_error) |-> (m_last_of_run && !m_frame_end && !m_pair))
        else $error("width error word carries write fields");

    a_error_holds_position: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && width_odd) |=> ($stable(col_reg) && $stable(row_reg)))
        else $error("position counters moved on a width error");

    a_frame_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_end) |-> m_last_of_run)
        else $error("frame end flagged on a word that is not last of its pair");

endmodule

`default_nettype wire
